// File: design/tmf_pkg.sv
package tmf_pkg;

  // Raw touch coordinate and mouse byte widths
  localparam int COORD_W = 16;
  localparam int MOUSE_W = 8;

  // Smoothing history and panel full scale
  localparam int HIST_DEPTH = 3;
  localparam int FULL_SCALE = 999;

  // A clamped coordinate holds 0..FULL_SCALE
  localparam int CLAMP_W = $clog2(FULL_SCALE + 1);

  // Mapping v -> (v*254 + 127) / FULL_SCALE - 127
  localparam int MAP_MUL = 254;
  localparam int MAP_OFS = 127;
  localparam logic [MOUSE_W-1:0] MAP_BIAS = MOUSE_W'(127);

  // Exact reciprocal for the division by FULL_SCALE: the numerator stays
  // below 2**23 and FULL_SCALE below 2**15, so a 38-bit shift is exact.
  localparam int DIV_SHIFT = 38;
  localparam int PROD_W = 64;
  localparam longint unsigned DIV_RECIP =
    ((64'd1 << DIV_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
  localparam logic [PROD_W-1:0] SCALE_K1 = PROD_W'(DIV_RECIP * 64'(MAP_MUL));
  localparam logic [PROD_W-1:0] SCALE_K0 = PROD_W'(DIV_RECIP * 64'(MAP_OFS));

  // Button bit masks of the frame
  localparam logic [1:0] BTN_LEFT  = 2'h1;
  localparam logic [1:0] BTN_RIGHT = 2'h2;

  // Clamp a raw signed coordinate to 0..FULL_SCALE
  function automatic logic [CLAMP_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [CLAMP_W-1:0] c;
    if (v[COORD_W-1]) begin
      c = '0;
    end else if (v[COORD_W-2:0] > (COORD_W-1)'(FULL_SCALE)) begin
      c = CLAMP_W'(FULL_SCALE);
    end else begin
      c = CLAMP_W'(v[COORD_W-2:0]);
    end
    return c;
  endfunction

endpackage

// File: design/touch_to_relative_mouse_frame.sv
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_stall  | touch_x, touch_y, left/right_pressed, sink_empty
// out      | out_valid / out_stall| frame_sent, button_bits, mouse_x, mouse_y
//
// One event per cycle sustained while out_stall is low; two register stages:
// point select and clamp into the input stage, then reciprocal multiply and
// bias into the result stage, which raises out_valid. The history shift is
// applied at the input transfer. Synchronous active-low reset clears the
// history, the press flag and both valid flags. A stall on out backs up into
// in_stall only when both stages hold an event.
module touch_to_relative_mouse_frame import tmf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_touch_x,
  input  logic signed [COORD_W-1:0] in_touch_y,
  input  logic                      in_left_pressed,
  input  logic                      in_right_pressed,
  input  logic                      in_sink_empty,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_frame_sent,
  output logic [1:0]                out_button_bits,
  output logic signed [MOUSE_W-1:0] out_mouse_x,
  output logic signed [MOUSE_W-1:0] out_mouse_y
);

  logic [COORD_W-1:0] x_hist_r [HIST_DEPTH];
  logic [COORD_W-1:0] y_hist_r [HIST_DEPTH];
  logic [COORD_W-1:0] x_hist_nxt [HIST_DEPTH];
  logic [COORD_W-1:0] y_hist_nxt [HIST_DEPTH];
  logic               prev_left_r;

  logic               s1_valid_r;
  logic [CLAMP_W-1:0] s1_x_r;
  logic [CLAMP_W-1:0] s1_y_r;
  logic [1:0]         s1_btn_r;
  logic               s1_empty_r;

  logic                      out_valid_r;
  logic                      out_sent_r;
  logic [1:0]                out_btn_r;
  logic signed [MOUSE_W-1:0] out_x_r;
  logic signed [MOUSE_W-1:0] out_y_r;

  logic                      in_xfer;
  logic                      out_adv;
  logic                      press_edge;
  logic                      tracking;
  logic [COORD_W-1:0]        emit_x;
  logic [COORD_W-1:0]        emit_y;
  logic signed [MOUSE_W-1:0] scaled_x;
  logic signed [MOUSE_W-1:0] scaled_y;

  // Flow control
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_xfer  = in_valid && !in_stall;

  // Pick the emitted point and the next history
  assign press_edge = in_left_pressed && !prev_left_r;
  assign tracking   = in_left_pressed || prev_left_r;

  always_comb begin
    emit_x = in_touch_x;
    emit_y = in_touch_y;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      x_hist_nxt[i] = x_hist_r[i];
      y_hist_nxt[i] = y_hist_r[i];
    end
    if (press_edge) begin
      // fill every slot with the current point
      for (int i = 0; i < HIST_DEPTH; i++) begin
        x_hist_nxt[i] = in_touch_x;
        y_hist_nxt[i] = in_touch_y;
      end
    end else if (tracking) begin
      emit_x = x_hist_r[0];
      emit_y = y_hist_r[0];
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
        x_hist_nxt[i] = x_hist_r[i+1];
        y_hist_nxt[i] = y_hist_r[i+1];
      end
      x_hist_nxt[HIST_DEPTH-1] = in_touch_x;
      y_hist_nxt[HIST_DEPTH-1] = in_touch_y;
    end
  end

  // Update history on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_left_r <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        x_hist_r[i] <= '0;
        y_hist_r[i] <= '0;
      end
    end else if (in_xfer) begin
      prev_left_r <= in_left_pressed;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        x_hist_r[i] <= x_hist_nxt[i];
        y_hist_r[i] <= y_hist_nxt[i];
      end
    end
  end

  // Input stage: clamped point, buttons, fifo status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x_r     <= clamp_coord(emit_x);
      s1_y_r     <= clamp_coord(emit_y);
      s1_btn_r   <= (in_left_pressed ? BTN_LEFT : 2'b00) |
                    (in_right_pressed ? BTN_RIGHT : 2'b00);
      s1_empty_r <= in_sink_empty;
    end
  end

  // Map both coordinates to the mouse byte range
  tmf_scale u_scale_x (
    .coord (s1_x_r),
    .mouse (scaled_x)
  );

  tmf_scale u_scale_y (
    .coord (s1_y_r),
    .mouse (scaled_y)
  );

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_sent_r <= s1_empty_r;
      out_btn_r  <= s1_btn_r;
      out_x_r    <= scaled_x;
      out_y_r    <= scaled_y;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_sent  = out_sent_r;
  assign out_button_bits = out_btn_r;
  assign out_mouse_x     = out_x_r;
  assign out_mouse_y     = out_y_r;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled without a held event");

  a_press_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && press_edge |=> x_hist_r[0] == $past(in_touch_x) &&
      y_hist_r[HIST_DEPTH-1] == $past(in_touch_y))
    else $error("press edge did not fill the history");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without an event in the input stage");

  a_mouse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_x_r != -8'sd128 && out_y_r != -8'sd128)
    else $error("mouse coordinate out of range");

endmodule

// File: design/tmf_scale.sv
module tmf_scale import tmf_pkg::*; (
  input  logic [CLAMP_W-1:0]        coord,
  output logic signed [MOUSE_W-1:0] mouse
);

  logic [PROD_W-1:0]  prod;
  logic [MOUSE_W-1:0] quot;

  // Multiply by the folded reciprocal, keep the quotient, remove the bias
  assign prod  = PROD_W'(coord) * SCALE_K1 + SCALE_K0;
  assign quot  = prod[DIV_SHIFT +: MOUSE_W];
  assign mouse = $signed(quot - MAP_BIAS);

endmodule
